@@ rtl/sce_pkg.sv @@
// ----------------------------------------------------------------------------
// sce_pkg
// Shared widths, codes, types and the quarter-wave sine table of the
// crossfade envelope.
// ----------------------------------------------------------------------------
package sce_pkg;

	localparam int TIME_W           = 24;
	localparam int TIME_FRAC_BITS   = 16;
	localparam int WEIGHT_W         = 17;
	localparam int RATIO_FRAC       = 16;
	localparam int RATIO_W          = RATIO_FRAC + 1;
	localparam int SINE_TABLE_DEPTH = 256;
	localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
	localparam int SINE_K_W         = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int DIV_CNT_W        = $clog2(RATIO_FRAC + 1);

	localparam logic [TIME_W-1:0]   TIME_MAX        = {TIME_W{1'b1}};
	localparam logic [TIME_W-1:0]   BLEND_TIME_RST  = TIME_W'(16384);
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE      = WEIGHT_W'(65536);
	localparam logic [WEIGHT_W-1:0] WEIGHT_FULL_MIN = WEIGHT_W'(65471);
	localparam logic [RATIO_W-1:0]  RATIO_ONE       = RATIO_W'(1) << RATIO_FRAC;
	localparam longint unsigned     HALF_PI_Q30     = 64'd1686629713;

	typedef logic [TIME_W-1:0]   time_t;
	typedef logic [WEIGHT_W-1:0] weight_t;
	typedef logic [RATIO_W-1:0]  ratio_t;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_START = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_INACTIVE    = 2'd0,
		ST_ACTIVE      = 2'd1,
		ST_DEACTIVATED = 2'd2
	} status_t;

	typedef struct packed {
		logic  start;
		time_t num;
		time_t den;
	} div_req_t;

	typedef struct packed {
		logic   done;
		ratio_t ratio;
	} div_rsp_t;

	typedef weight_t sine_rom_t [SINE_TABLE_DEPTH];

	// Taylor series to x^11 in Q30, rounded to Q1.16
	function automatic weight_t sine_entry(input int unsigned k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		longint unsigned w;
		x    = (longint'(k) * HALF_PI_Q30 + longint'(SINE_TABLE_DEPTH / 2))
		       / SINE_TABLE_DEPTH;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		term = ((term * x2) >> 30) / 6;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 20;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 42;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 72;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 110;
		sum  = sum - longint'(term);
		if (sum < 0) begin
			sum = 0;
		end
		w = (longint'(sum) + 8192) >> 14;
		if (w > 65536) begin
			w = 65536;
		end
		return WEIGHT_W'(w);
	endfunction

	function automatic sine_rom_t sine_rom_init();
		sine_rom_t t;
		for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
			t[i] = sine_entry(i);
		end
		return t;
	endfunction

	localparam sine_rom_t SINE_ROM = sine_rom_init();
	localparam weight_t   SINE_TOP = sine_entry(SINE_TABLE_DEPTH);

endpackage

@@ rtl/sce_item_if.sv @@
// ----------------------------------------------------------------------------
// sce_item_if
// Input channel of the crossfade envelope: one tick or start item per
// transfer.
// ----------------------------------------------------------------------------
interface sce_item_if;
	import sce_pkg::*;

	logic    valid;
	logic    ready;
	opcode_t opcode;
	time_t   delta_time;
	logic    is_current;
	logic    start_active;
	weight_t start_weight;
	time_t   clip_start_time;
	time_t   time_offset;
	time_t   pose_offset;
	time_t   clip_length;
	logic    loop_enable;

	modport source (
		output valid, opcode, delta_time, is_current, start_active, start_weight,
		       clip_start_time, time_offset, pose_offset, clip_length, loop_enable,
		input  ready
	);

	modport sink (
		input  valid, opcode, delta_time, is_current, start_active, start_weight,
		       clip_start_time, time_offset, pose_offset, clip_length, loop_enable,
		output ready
	);
endinterface

@@ rtl/sce_result_if.sv @@
// ----------------------------------------------------------------------------
// sce_result_if
// Result channel of the crossfade envelope: weight, status and play time
// per transfer.
// ----------------------------------------------------------------------------
interface sce_result_if;
	import sce_pkg::*;

	logic    valid;
	logic    ready;
	weight_t weight;
	status_t channel_status;
	time_t   play_time;

	modport source (
		output valid, weight, channel_status, play_time,
		input  ready
	);

	modport sink (
		input  valid, weight, channel_status, play_time,
		output ready
	);
endinterface

@@ rtl/sce_ratio_div.sv @@
// ----------------------------------------------------------------------------
// sce_ratio_div
// Radix-2 restoring divider for the fade ratio num / den in Q1.16, clamped
// to 1.0; one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sce_ratio_div (
	input  logic             clk,
	input  logic             arst_n,
	input  sce_pkg::div_req_t req,
	output sce_pkg::div_rsp_t rsp
);
	import sce_pkg::*;

	logic                    busy_q;
	logic                    done_q;
	logic                    sat_q;
	logic [DIV_CNT_W-1:0]    cnt_q;
	time_t                   rem_q;
	time_t                   den_q;
	logic [RATIO_FRAC-1:0]   quo_q;
	logic [TIME_W:0]         rem2;
	logic                    ge;

	assign rem2 = {rem_q, 1'b0};
	assign ge   = rem2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			sat_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (req.num >= req.den) begin
					sat_q  <= 1'b1;
					done_q <= 1'b1;
					busy_q <= 1'b0;
				end else begin
					sat_q  <= 1'b0;
					busy_q <= 1'b1;
					cnt_q  <= DIV_CNT_W'(RATIO_FRAC);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? TIME_W'(rem2 - {1'b0, den_q}) : rem2[TIME_W-1:0];
			quo_q <= {quo_q[RATIO_FRAC-2:0], ge};
		end
	end

	assign rsp.done  = done_q;
	assign rsp.ratio = sat_q ? RATIO_ONE : {1'b0, quo_q};

endmodule

@@ rtl/sce_sine_lookup.sv @@
// ----------------------------------------------------------------------------
// sce_sine_lookup
// Rounds the Q1.16 ratio to a table index and reads sin(pi/2 * k / depth)
// from the constant table, registered.
// ----------------------------------------------------------------------------
module sce_sine_lookup (
	input  logic            clk,
	input  sce_pkg::ratio_t ratio,
	output sce_pkg::weight_t sine
);
	import sce_pkg::*;

	localparam int KP_W = RATIO_W + SINE_K_W + 1;

	logic [KP_W-1:0]     kprod;
	logic [SINE_K_W-1:0] k;
	weight_t             sine_q;

	assign kprod = KP_W'(ratio) * KP_W'(SINE_TABLE_DEPTH) + KP_W'(32768);
	assign k     = kprod[RATIO_FRAC +: SINE_K_W];

	always_ff @(posedge clk) begin
		if (k >= SINE_K_W'(SINE_TABLE_DEPTH)) begin
			sine_q <= SINE_TOP;
		end else begin
			sine_q <= SINE_ROM[k[SINE_IDX_W-1:0]];
		end
	end

	assign sine = sine_q;

endmodule

@@ rtl/sine_crossfade_channel_weight_core.sv @@
// ----------------------------------------------------------------------------
// sine_crossfade_channel_weight_core
// Crossfade envelope of one blend channel: start and tick items in, one
// weight / status / play time result out for every item.
// ----------------------------------------------------------------------------
// Items arrive on the item channel, results leave on the result channel;
// both transfer on valid and ready high at a rising edge. blend_time is
// written through cfg_wr_en / cfg_wr_data; the user must write it only
// while the block is idle, and the block does not enforce this. A start
// item or a tick on an inactive channel goes from execute to the output
// step. A tick on an active channel runs the ratio divider, one quotient
// bit a cycle, then the sine table read and, when fading out, one multiply;
// the divider skips its iterations when the ratio clamps to 1.0. One item
// is in work at a time; item.ready is high only while the sequencer is
// idle, and a waiting result does not block the next transfer in.
// The result sits in an output register until taken; a stalled receiver
// holds the sequencer at its final step, with the channel state already
// updated. Reset clears the channel (inactive, all times and weights zero)
// and sets blend_time to 0.25 s.
// ----------------------------------------------------------------------------
module sine_crossfade_channel_weight_core (
	input  logic           clk,
	input  logic           arst_n,
	sce_item_if.sink       item,
	sce_result_if.source   result,
	input  logic           cfg_wr_en,
	input  sce_pkg::time_t cfg_wr_data
);
	import sce_pkg::*;

	localparam int    AGE_FULL_I = ((3 << TIME_FRAC_BITS) + 5) / 10;
	localparam time_t AGE_FULL   = TIME_W'(AGE_FULL_I);
	localparam int    CMP_W      = (WEIGHT_W + TIME_FRAC_BITS > TIME_W + RATIO_FRAC) ?
	                               WEIGHT_W + TIME_FRAC_BITS : TIME_W + RATIO_FRAC;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DIVGO,
		S_DIV,
		S_ROM,
		S_SINE,
		S_MUL,
		S_OUT
	} state_t;

	function automatic time_t sat_add(input time_t a, input time_t b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
	endfunction

	state_t  state_q;
	status_t status_q;

	opcode_t op_q;
	time_t   delta_q;
	logic    cur_q;
	logic    sact_q;
	weight_t sw_q;
	time_t   cst_q;
	time_t   toff_q;
	time_t   poff_q;
	time_t   clen_q;
	logic    loop_q;

	time_t   blend_q;
	time_t   play_q;
	time_t   age_q;
	time_t   decay_q;
	weight_t weight_q;
	weight_t peak_q;
	logic    active_q;
	logic    looping_q;
	time_t   clip_q;

	logic [2*WEIGHT_W-1:0] prod_q;

	logic    out_valid_q;
	weight_t out_weight_q;
	status_t out_status_q;
	time_t   out_play_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	weight_t  sine;

	weight_t               sw_clamp;
	logic [TIME_W+1:0]     pt_start;
	time_t                 pt_start_sat;
	logic [TIME_W:0]       pt_tick;
	logic [TIME_W:0]       pt_wrap;
	time_t                 pt_tick_sat;
	logic [2*WEIGHT_W-1:0] w_round;
	weight_t               w_fade;
	logic [CMP_W-1:0]      w_cmp;
	logic [CMP_W-1:0]      d_cmp;

	assign sw_clamp     = (sw_q > WEIGHT_ONE) ? WEIGHT_ONE : sw_q;
	assign pt_start     = (TIME_W+2)'(cst_q) + (TIME_W+2)'(toff_q) + (TIME_W+2)'(poff_q);
	assign pt_start_sat = (pt_start > (TIME_W+2)'(TIME_MAX)) ? TIME_MAX
	                                                         : pt_start[TIME_W-1:0];
	assign pt_tick      = {1'b0, play_q} + {1'b0, delta_q};
	assign pt_wrap      = (looping_q && pt_tick > {1'b0, clip_q}) ?
	                      pt_tick - {1'b0, clip_q} : pt_tick;
	assign pt_tick_sat  = pt_wrap[TIME_W] ? TIME_MAX : pt_wrap[TIME_W-1:0];
	assign w_round      = prod_q + (2*WEIGHT_W)'(32768);
	assign w_fade       = w_round[RATIO_FRAC +: WEIGHT_W];
	assign w_cmp        = CMP_W'(w_fade) << TIME_FRAC_BITS;
	assign d_cmp        = CMP_W'(delta_q) << RATIO_FRAC;

	assign div_req.start = (state_q == S_DIVGO);
	assign div_req.num   = cur_q ? age_q : decay_q;
	assign div_req.den   = blend_q;

	sce_ratio_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	sce_sine_lookup u_sine (
		.clk   (clk),
		.ratio (div_rsp.ratio),
		.sine  (sine)
	);

	assign item.ready            = (state_q == S_IDLE);
	assign result.valid          = out_valid_q;
	assign result.weight         = out_weight_q;
	assign result.channel_status = out_status_q;
	assign result.play_time      = out_play_q;

	// item capture and fade-out product
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_q    <= item.opcode;
			delta_q <= item.delta_time;
			cur_q   <= item.is_current;
			sact_q  <= item.start_active;
			sw_q    <= item.start_weight;
			cst_q   <= item.clip_start_time;
			toff_q  <= item.time_offset;
			poff_q  <= item.pose_offset;
			clen_q  <= item.clip_length;
			loop_q  <= item.loop_enable;
		end
		if (state_q == S_SINE) begin
			prod_q <= (2*WEIGHT_W)'(peak_q) * (2*WEIGHT_W)'(WEIGHT_ONE - sine);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			status_q     <= ST_INACTIVE;
			blend_q      <= BLEND_TIME_RST;
			play_q       <= '0;
			age_q        <= '0;
			decay_q      <= '0;
			weight_q     <= '0;
			peak_q       <= '0;
			active_q     <= 1'b0;
			looping_q    <= 1'b0;
			clip_q       <= '0;
			out_valid_q  <= 1'b0;
			out_weight_q <= '0;
			out_status_q <= ST_INACTIVE;
			out_play_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				blend_q <= cfg_wr_data;
			end
			if (result.ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (op_q == OP_START) begin
						weight_q  <= sw_clamp;
						peak_q    <= sw_clamp;
						active_q  <= sact_q;
						clip_q    <= clen_q;
						looping_q <= loop_q;
						decay_q   <= '0;
						age_q     <= (sw_clamp >= WEIGHT_FULL_MIN) ? sat_add(AGE_FULL, toff_q)
						                                           : toff_q;
						play_q    <= (pt_start_sat > clen_q) ? clen_q : pt_start_sat;
						status_q  <= sact_q ? ST_ACTIVE : ST_INACTIVE;
						state_q   <= S_OUT;
					end else if (!active_q) begin
						status_q <= ST_INACTIVE;
						state_q  <= S_OUT;
					end else begin
						play_q   <= pt_tick_sat;
						status_q <= ST_ACTIVE;
						if (cur_q) begin
							age_q <= sat_add(age_q, delta_q);
						end
						state_q <= S_DIVGO;
					end
				end
				S_DIVGO: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_ROM;
					end
				end
				S_ROM: begin
					state_q <= S_SINE;
				end
				S_SINE: begin
					if (cur_q) begin
						weight_q <= sine;
						peak_q   <= sine;
						state_q  <= S_OUT;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (w_cmp < d_cmp) begin
						weight_q <= '0;
						peak_q   <= '0;
						age_q    <= '0;
						decay_q  <= '0;
						active_q <= 1'b0;
						status_q <= ST_DEACTIVATED;
					end else begin
						weight_q <= w_fade;
						age_q    <= sat_add(age_q, delta_q);
						decay_q  <= sat_add(decay_q, delta_q);
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q  <= 1'b1;
						out_weight_q <= active_q ? weight_q : '0;
						out_status_q <= status_q;
						out_play_q   <= play_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV)
		else $error("divider finished outside the divide step");

	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.weight <= WEIGHT_ONE)
		else $error("result weight above 1.0");

	a_inactive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.channel_status == ST_INACTIVE ||
		                 result.channel_status == ST_DEACTIVATED) |-> result.weight == '0)
		else $error("inactive channel reports a nonzero weight");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("second item taken while one is in work");
`endif

endmodule

@@ tb/sv/sine_crossfade_channel_weight_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_crossfade_channel_weight_core_tb
// Drives start and tick items into the crossfade envelope under random
// sender gaps and receiver stalls, predicts every weight / status / play
// time result in fixed point and compares each transfer field by field,
// across several blend_time settings including zero and full scale.
// ----------------------------------------------------------------------------
module sine_crossfade_channel_weight_core_tb;
	import sce_pkg::*;

	localparam int RANDOM_ITEMS   = 400;
	localparam int SETTLE_CYCLES  = 30;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int STALL_LIMIT    = 4000;
	localparam int PHASES         = 6;
	localparam longint unsigned FULL_AGE_BOOST = ((64'd3 << TIME_FRAC_BITS) + 64'd5) / 64'd10;

	typedef struct {
		opcode_t op;
		time_t   delta;
		logic    cur;
		logic    act;
		weight_t sw;
		time_t   cst;
		time_t   toff;
		time_t   poff;
		time_t   clen;
		logic    looped;
	} chan_item_t;

	typedef struct {
		weight_t weight;
		status_t status;
		time_t   play;
	} envelope_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  cfg_wr_en;
	time_t cfg_wr_data;
	logic  calm;
	logic  holdoff_active;

	sce_item_if   item_ch();
	sce_result_if result_ch();

	sine_crossfade_channel_weight_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.result      (result_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// predictor state
	time_t   blend_ref;
	time_t   env_play;
	time_t   env_age;
	time_t   env_decay;
	weight_t env_weight;
	weight_t env_peak;
	logic    env_active;
	logic    env_loop;
	time_t   env_clip;

	envelope_t envelope_q[$];

	int fail_count = 0;
	int n_items = 0;
	int n_starts = 0;
	int n_ticks = 0;
	int n_results = 0;
	int n_deact = 0;
	int n_cfg = 0;
	int quiet_cycles = 0;
	int holdoff_asked = 0;
	int holdoff_served = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic time_t sat_time24(input longint unsigned v);
		return (v > 64'(TIME_MAX)) ? TIME_MAX : time_t'(v);
	endfunction

	function automatic weight_t quarter_sine(input int unsigned k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned w;
		longint          acc;
		x    = (64'(k) * HALF_PI_Q30 + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
		x2   = (x * x) >> 30;
		term = x;
		acc  = longint'(x);
		for (int n = 1; n <= 5; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		w = ($unsigned(acc) + 64'd8192) >> 14;
		if (w > 64'(WEIGHT_ONE)) begin
			w = 64'(WEIGHT_ONE);
		end
		return weight_t'(w);
	endfunction

	function automatic weight_t fade_sine(input time_t t);
		longint unsigned ratio;
		int unsigned     k;
		if (blend_ref == '0) begin
			ratio = 64'(WEIGHT_ONE);
		end else begin
			ratio = (64'(t) << 16) / 64'(blend_ref);
			if (ratio > 64'(WEIGHT_ONE)) begin
				ratio = 64'(WEIGHT_ONE);
			end
		end
		k = 32'((ratio * 64'(SINE_TABLE_DEPTH) + 64'd32768) >> 16);
		return quarter_sine(k);
	endfunction

	function automatic envelope_t advance_envelope(input chan_item_t it);
		envelope_t       res;
		longint unsigned sum;
		longint unsigned prod;
		weight_t         w;
		weight_t         s;
		status_t         st;
		if (it.op == OP_START) begin
			w = (it.sw > WEIGHT_ONE) ? WEIGHT_ONE : it.sw;
			env_weight = w;
			env_peak   = w;
			env_active = it.act;
			env_clip   = it.clen;
			env_loop   = it.looped;
			env_decay  = '0;
			if (w >= WEIGHT_FULL_MIN) begin
				env_age = sat_time24(FULL_AGE_BOOST + 64'(it.toff));
			end else begin
				env_age = it.toff;
			end
			env_play = sat_time24(64'(it.cst) + 64'(it.toff) + 64'(it.poff));
			if (env_play > env_clip) begin
				env_play = env_clip;
			end
			st = it.act ? ST_ACTIVE : ST_INACTIVE;
		end else if (!env_active) begin
			st = ST_INACTIVE;
		end else begin
			sum = 64'(env_play) + 64'(it.delta);
			if (env_loop && sum > 64'(env_clip)) begin
				sum = sum - 64'(env_clip);
			end
			env_play = sat_time24(sum);
			st = ST_ACTIVE;
			if (it.cur) begin
				env_age    = sat_time24(64'(env_age) + 64'(it.delta));
				env_weight = fade_sine(env_age);
				env_peak   = env_weight;
			end else begin
				s    = fade_sine(env_decay);
				prod = (64'(env_peak) * (64'(WEIGHT_ONE) - 64'(s)) + 64'd32768) >> 16;
				env_weight = weight_t'(prod);
				if ((64'(env_weight) << TIME_FRAC_BITS) < (64'(it.delta) << 16)) begin
					env_weight = '0;
					env_peak   = '0;
					env_age    = '0;
					env_decay  = '0;
					env_active = 1'b0;
					st         = ST_DEACTIVATED;
					n_deact++;
				end else begin
					env_age   = sat_time24(64'(env_age) + 64'(it.delta));
					env_decay = sat_time24(64'(env_decay) + 64'(it.delta));
				end
			end
		end
		res.weight = env_active ? env_weight : '0;
		res.status = st;
		res.play   = env_play;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic check_envelope();
		envelope_t want;
		if (envelope_q.size() == 0) begin
			report_mismatch($sformatf("result with nothing expected: w=%0d st=%0d pt=%0d",
				result_ch.weight, result_ch.channel_status, result_ch.play_time));
			return;
		end
		want = envelope_q.pop_front();
		n_results++;
		if (result_ch.weight !== want.weight)
			report_mismatch($sformatf("result %0d weight got %0d want %0d",
				n_results, result_ch.weight, want.weight));
		if (result_ch.channel_status !== want.status)
			report_mismatch($sformatf("result %0d status got %0d want %0d",
				n_results, result_ch.channel_status, want.status));
		if (result_ch.play_time !== want.play)
			report_mismatch($sformatf("result %0d play_time got %0d want %0d",
				n_results, result_ch.play_time, want.play));
	endtask

	// receiver: check each transfer, then drive ready for the next edge
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (result_ch.valid && result_ch.ready) begin
					check_envelope();
				end
				result_ch.ready <= !holdoff_active && (calm || $urandom_range(99) >= 26);
			end
		end
	end

	// receiver hold-off, counted here
	initial begin
		holdoff_active <= 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_asked != holdoff_served) begin
				holdoff_active <= 1'b1;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
				holdoff_active <= 1'b0;
				holdoff_served++;
			end
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", quiet_cycles);
			$display("simulation failed");
			$finish;
		end
	end

	function automatic chan_item_t make_start(input logic act, input weight_t sw,
			input time_t cst, input time_t toff, input time_t poff, input time_t clen,
			input logic looped);
		chan_item_t it;
		it.op     = OP_START;
		it.delta  = time_t'($urandom);
		it.cur    = 1'($urandom_range(1));
		it.act    = act;
		it.sw     = sw;
		it.cst    = cst;
		it.toff   = toff;
		it.poff   = poff;
		it.clen   = clen;
		it.looped = looped;
		return it;
	endfunction

	function automatic chan_item_t make_tick(input time_t delta, input logic cur);
		chan_item_t it;
		it.op     = OP_TICK;
		it.delta  = delta;
		it.cur    = cur;
		it.act    = 1'($urandom_range(1));
		it.sw     = weight_t'($urandom);
		it.cst    = time_t'($urandom);
		it.toff   = time_t'($urandom);
		it.poff   = time_t'($urandom);
		it.clen   = time_t'($urandom);
		it.looped = 1'($urandom_range(1));
		return it;
	endfunction

	function automatic time_t rand_time();
		case ($urandom_range(9))
			0: return '0;
			1: return TIME_MAX;
			2, 3: return time_t'($urandom);
			default: return time_t'($urandom_range(0, 32'h3FFFF));
		endcase
	endfunction

	function automatic weight_t rand_start_weight();
		case ($urandom_range(9))
			0, 1: return WEIGHT_ONE;
			2: return weight_t'($urandom_range(65471, 65535));
			3: return weight_t'($urandom_range(65537, 131071));
			4: return '0;
			default: return weight_t'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic time_t pick_delta();
		int unsigned r;
		int unsigned span;
		r = $urandom_range(99);
		if (r < 5) return '0;
		if (r < 10) return time_t'($urandom);
		if (r < 13) return TIME_MAX;
		span = (blend_ref == '0) ? 4096 : (32'(blend_ref) >> 2);
		if (span > 65536) span = 65536;
		if (span == 0) span = 1;
		return time_t'($urandom_range(1, span));
	endfunction

	task automatic send_item(input chan_item_t it);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(99) < 26) begin
			gap = $urandom_range(1, 30);
		end
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid           <= 1'b1;
		item_ch.opcode          <= it.op;
		item_ch.delta_time      <= it.delta;
		item_ch.is_current      <= it.cur;
		item_ch.start_active    <= it.act;
		item_ch.start_weight    <= it.sw;
		item_ch.clip_start_time <= it.cst;
		item_ch.time_offset     <= it.toff;
		item_ch.pose_offset     <= it.poff;
		item_ch.clip_length     <= it.clen;
		item_ch.loop_enable     <= it.looped;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		envelope_q.push_back(advance_envelope(it));
		n_items++;
		if (it.op == OP_START) n_starts++;
		else n_ticks++;
	endtask

	task automatic drain_block();
		item_ch.valid <= 1'b0;
		while (envelope_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_blend(input time_t v);
		drain_block();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		blend_ref = v;
		n_cfg++;
	endtask

	task automatic test_idle_after_reset();
		send_item(make_tick(TIME_MAX, 1'b1));
		send_item(make_tick('0, 1'b0));
	endtask

	task automatic test_start_loading();
		send_item(make_start(1'b1, weight_t'(131071), TIME_MAX, TIME_MAX, TIME_MAX,
			TIME_MAX, 1'b1));
		send_item(make_start(1'b0, '0, time_t'(100), '0, '0, time_t'(50), 1'b0));
		send_item(make_start(1'b1, weight_t'(65470), time_t'(7), time_t'(1000), '0,
			time_t'(32'h40000), 1'b0));
		send_item(make_tick(time_t'(1000), 1'b1));
		send_item(make_start(1'b1, WEIGHT_FULL_MIN, '0, time_t'(1000), time_t'(5),
			time_t'(32'h40000), 1'b0));
		send_item(make_tick(time_t'(1000), 1'b0));
	endtask

	task automatic test_fade_in_wrap();
		send_item(make_start(1'b1, '0, '0, '0, '0, time_t'(32'h30000), 1'b1));
		repeat (3) send_item(make_tick(time_t'(32'h2000), 1'b1));
		send_item(make_tick(time_t'(32'h30000), 1'b1));
		send_item(make_tick(TIME_MAX, 1'b1));
	endtask

	task automatic test_fade_out_release();
		int guard;
		guard = 0;
		send_item(make_start(1'b1, WEIGHT_ONE, '0, '0, '0, time_t'(32'h10000), 1'b0));
		while (env_active && guard < 12) begin
			send_item(make_tick(time_t'(32'h1000), 1'b0));
			guard++;
		end
		send_item(make_tick(time_t'(32'h1000), 1'b0));
	endtask

	task automatic test_zero_blend();
		write_blend('0);
		send_item(make_start(1'b1, weight_t'(100), '0, '0, '0, time_t'(32'h8000), 1'b0));
		send_item(make_tick(time_t'(1), 1'b1));
		send_item(make_tick(time_t'(1), 1'b0));
	endtask

	task automatic test_backpressure();
		write_blend(BLEND_TIME_RST);
		calm <= 1'b1;
		@(posedge clk);
		holdoff_asked++;
		send_item(make_start(1'b1, weight_t'(30000), '0, '0, '0, time_t'(32'h20000), 1'b1));
		repeat (7) send_item(make_tick(time_t'(32'h800), 1'b1));
		drain_block();
		calm <= 1'b0;
	endtask

	task automatic run_random_items(input int count);
		int   stop;
		int   fade_in_ticks;
		int   guard;
		logic cur;
		stop = n_items + count;
		while (n_items < stop) begin
			if ($urandom_range(99) < 10) begin
				send_item(make_start(1'($urandom_range(1)), weight_t'($urandom),
					time_t'($urandom), time_t'($urandom), time_t'($urandom),
					time_t'($urandom), 1'($urandom_range(1))));
				if ($urandom_range(1) == 0) begin
					send_item(make_tick(time_t'($urandom), 1'($urandom_range(1))));
				end
			end else begin
				send_item(make_start($urandom_range(99) < 90, rand_start_weight(),
					rand_time(), rand_time(), rand_time(), rand_time(),
					1'($urandom_range(1))));
				fade_in_ticks = $urandom_range(0, 10);
				guard = 0;
				while (env_active && guard < 40 && n_items < stop) begin
					cur = (guard < fade_in_ticks) ? ($urandom_range(99) >= 5)
						: ($urandom_range(99) < 5);
					send_item(make_tick(pick_delta(), cur));
					guard++;
				end
			end
		end
	endtask

	task automatic test_random_phases();
		time_t settings [PHASES];
		settings[0] = BLEND_TIME_RST;
		settings[1] = '0;
		settings[2] = TIME_MAX;
		settings[3] = time_t'(1);
		settings[4] = time_t'($urandom_range(2048, 131072));
		settings[5] = time_t'($urandom);
		for (int i = 0; i < PHASES; i++) begin
			write_blend(settings[i]);
			calm <= (i == 0);
			run_random_items(RANDOM_ITEMS / PHASES);
		end
		calm <= 1'b0;
	endtask

	initial begin
		item_ch.valid           <= 1'b0;
		item_ch.opcode          <= OP_TICK;
		item_ch.delta_time      <= '0;
		item_ch.is_current      <= 1'b0;
		item_ch.start_active    <= 1'b0;
		item_ch.start_weight    <= '0;
		item_ch.clip_start_time <= '0;
		item_ch.time_offset     <= '0;
		item_ch.pose_offset     <= '0;
		item_ch.clip_length     <= '0;
		item_ch.loop_enable     <= 1'b0;
		cfg_wr_en               <= 1'b0;
		cfg_wr_data             <= '0;
		calm                    <= 1'b0;
		blend_ref  = BLEND_TIME_RST;
		env_play   = '0;
		env_age    = '0;
		env_decay  = '0;
		env_weight = '0;
		env_peak   = '0;
		env_active = 1'b0;
		env_loop   = 1'b0;
		env_clip   = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_after_reset();
		write_blend(BLEND_TIME_RST);
		test_start_loading();
		test_fade_in_wrap();
		test_fade_out_release();
		test_zero_blend();
		test_backpressure();
		test_random_phases();

		drain_block();
		if (envelope_q.size() != 0) begin
			report_mismatch($sformatf("%0d expected results never arrived",
				envelope_q.size()));
		end
		$display("covered %0d items (%0d starts, %0d ticks), %0d results, %0d deactivations",
			n_items, n_starts, n_ticks, n_results, n_deact);
		$display("%0d blend_time writes incl. zero and full scale, %0d-cycle receiver hold-off",
			n_cfg, HOLDOFF_CYCLES);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
